### hw/rtl/ddd_pkg.sv
// Shared types and constants for the decimal digit display formatter.
// No dependencies; imported by ddd_cell and the top level.
package ddd_pkg;

    localparam int VALUE_W    = 32;  // binary input width
    localparam int POINT_W    = 5;   // signed point position
    localparam int INDEX_W    = 4;   // digit register index
    localparam int CODE_W     = 8;   // code-B value
    localparam int DIGIT_W    = 4;   // one BCD digit
    localparam int BCD_CELLS  = 10;  // enough decimal digits for VALUE_W bits
    localparam int BIT_CNT_W  = 5;   // counts VALUE_W conversion steps
    localparam int S_TDATA_W  = 40;  // value, point_digit, zero fill
    localparam int M_TDATA_W  = 16;  // digit_index, digit_code, zero fill

    localparam int DIGIT_COUNT_DEFAULT = 8;

    localparam logic [CODE_W-1:0] CODE_BLANK = 8'h0F;
    localparam logic [CODE_W-1:0] CODE_POINT = 8'h80;

    // Operation broadcast to every cell of the chain
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_DABBLE,   // add-3 correction, then shift one bit in from below
        CELL_SHIFT     // take the digit of the upper neighbor
    } cell_op_t;

endpackage

### hw/rtl/ddd_cell.sv
// One BCD digit cell of the conversion chain.
// Depends on ddd_pkg (cell_op_t, DIGIT_W).
module ddd_cell (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  ddd_pkg::cell_op_t        op,
    input  logic                     bit_in,     // from lower neighbor (dabble)
    input  logic [ddd_pkg::DIGIT_W-1:0] digit_in, // from upper neighbor (shift)
    output logic                     carry_out,  // to upper neighbor (dabble)
    output logic [ddd_pkg::DIGIT_W-1:0] digit,
    output logic                     nonzero
);
    import ddd_pkg::*;

    logic [DIGIT_W-1:0] digit_reg;
    logic [DIGIT_W-1:0] digit_next;
    logic [DIGIT_W-1:0] adj;

    // add 3 when the digit would overflow after doubling
    assign adj       = (digit_reg >= DIGIT_W'(5)) ? digit_reg + DIGIT_W'(3) : digit_reg;
    assign carry_out = adj[DIGIT_W-1];
    assign digit     = digit_reg;
    assign nonzero   = |digit_reg;

    always_comb begin
        case (op)
            CELL_CLEAR:  digit_next = '0;
            CELL_DABBLE: digit_next = {adj[DIGIT_W-2:0], bit_in};
            CELL_SHIFT:  digit_next = digit_in;
            default:     digit_next = digit_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digit_reg <= '0;
        end else begin
            digit_reg <= digit_next;
        end
    end

    a_digit_decimal: assert property (@(posedge aclk) disable iff (!aresetn)
        digit_reg <= DIGIT_W'(9))
        else $error("cell holds a non-decimal digit");

endmodule

### hw/rtl/decimal_digit_display_formatter.sv
// Decimal digit display formatter: binary to BCD by a chain of digit cells,
// then per-digit code-B writes. Depends on ddd_pkg and ddd_cell.
//
//  channel   dir  fields (tdata low bit up)                 extra
//  s_axis    in   value[31:0], point_digit[36:32], 0 fill    -
//  m_axis    out  digit_index[3:0], digit_code[11:4], 0 fill tlast = last
//
// Steps per request: 1 accept + 32 double-dabble steps through the cell
// chain + 1 trim check + one step per dropped low digit (0..2 for 8 digits)
// + DIGIT_COUNT digit writes.
// The 32-step loop over the shared cell chain takes up most of each request.
// Reset (aresetn low, synchronous) empties the output register and returns to idle.
// A stalled sink holds the output register; the chain waits for it.
// A new request is taken while the last digit write still waits.
module decimal_digit_display_formatter #(
    parameter int DIGIT_COUNT = ddd_pkg::DIGIT_COUNT_DEFAULT  // 1..8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [ddd_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // value, point_digit
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [ddd_pkg::M_TDATA_W-1:0]   m_axis_tdata,  // digit_index, digit_code
    output logic                            m_axis_tlast
);
    import ddd_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,   // double-dabble shifting
        ST_TRIM,   // drop low digits while too many remain
        ST_EMIT    // one digit write per free output slot
    } state_t;

    localparam logic signed [POINT_W-1:0] PT_NONE = POINT_W'(-1);
    localparam logic signed [POINT_W-1:0] PT_MAX  = POINT_W'(DIGIT_COUNT);
    localparam logic [INDEX_W-1:0]        IDX_LAST = INDEX_W'(DIGIT_COUNT);

    state_t                 state_reg, state_next;
    logic [VALUE_W-1:0]     value_reg, value_next;
    logic [INDEX_W-1:0]     pos_reg, pos_next;     // one-based point digit, 0 none
    logic [BIT_CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [INDEX_W-1:0]     idx_reg, idx_next;
    logic                   m_valid_reg, m_valid_next;
    logic [INDEX_W-1:0]     m_index_reg, m_index_next;
    logic [CODE_W-1:0]      m_code_reg, m_code_next;
    logic                   m_last_reg, m_last_next;

    cell_op_t               cell_op;
    logic [BCD_CELLS-1:0]   carry;
    logic [BCD_CELLS-1:0]   nz;
    logic [DIGIT_W-1:0]     digits [BCD_CELLS];

    logic                   s_accept;
    logic                   out_free;
    logic                   need_trim;
    logic                   any_left;
    logic signed [POINT_W-1:0] pt_in, pt_clamp;
    logic [CODE_W-1:0]      code;

    // ---------------- cell chain, cell 0 is the least significant digit
    for (genvar k = 0; k < BCD_CELLS; k++) begin : g_cell
        logic               bit_from_below;
        logic [DIGIT_W-1:0] digit_from_above;

        if (k == 0) begin : g_low
            assign bit_from_below = value_reg[VALUE_W-1];
        end else begin : g_mid
            assign bit_from_below = carry[k-1];
        end
        if (k == BCD_CELLS - 1) begin : g_top
            assign digit_from_above = '0;
        end else begin : g_below
            assign digit_from_above = digits[k+1];
        end

        ddd_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .op        (cell_op),
            .bit_in    (bit_from_below),
            .digit_in  (digit_from_above),
            .carry_out (carry[k]),
            .digit     (digits[k]),
            .nonzero   (nz[k])
        );
    end

    // more than DIGIT_COUNT decimal digits still present
    always_comb begin
        need_trim = 1'b0;
        for (int k = 0; k < BCD_CELLS; k++) begin
            if (k >= DIGIT_COUNT) begin
                need_trim = need_trim | nz[k];
            end
        end
    end
    assign any_left = |nz;

    // ---------------- request intake
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    assign pt_in = s_axis_tdata[VALUE_W +: POINT_W];
    always_comb begin
        if (pt_in < PT_NONE) begin
            pt_clamp = PT_NONE;
        end else if (pt_in > PT_MAX) begin
            pt_clamp = PT_MAX;
        end else begin
            pt_clamp = pt_in;
        end
    end

    // code for the digit now in cell 0
    always_comb begin
        if (idx_reg < pos_reg) begin
            code = CODE_W'(digits[0]);
        end else if (idx_reg == pos_reg) begin
            code = CODE_W'(digits[0]) | CODE_POINT;
        end else if (any_left) begin
            code = CODE_W'(digits[0]);
        end else begin
            code = CODE_BLANK;
        end
    end

    // ---------------- control
    always_comb begin
        state_next   = state_reg;
        value_next   = value_reg;
        pos_next     = pos_reg;
        bit_cnt_next = bit_cnt_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_index_next = m_index_reg;
        m_code_next  = m_code_reg;
        m_last_next  = m_last_reg;
        cell_op      = CELL_HOLD;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    value_next   = s_axis_tdata[VALUE_W-1:0];
                    pos_next     = INDEX_W'(pt_clamp + POINT_W'(1));
                    bit_cnt_next = '0;
                    cell_op      = CELL_CLEAR;
                    state_next   = ST_CONV;
                end
            end
            ST_CONV: begin
                cell_op      = CELL_DABBLE;
                value_next   = {value_reg[VALUE_W-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + BIT_CNT_W'(1);
                if (bit_cnt_reg == BIT_CNT_W'(VALUE_W - 1)) begin
                    state_next = ST_TRIM;
                end
            end
            ST_TRIM: begin
                if (need_trim) begin
                    cell_op = CELL_SHIFT;
                end else begin
                    idx_next   = INDEX_W'(1);
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_index_next = idx_reg;
                    m_code_next  = code;
                    m_last_next  = (idx_reg == IDX_LAST);
                    cell_op      = CELL_SHIFT;
                    idx_next     = idx_reg + INDEX_W'(1);
                    if (idx_reg == IDX_LAST) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            bit_cnt_reg <= '0;
            idx_reg     <= INDEX_W'(1);
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            bit_cnt_reg <= bit_cnt_next;
            idx_reg     <= idx_next;
        end
        value_reg   <= value_next;
        pos_reg     <= pos_next;
        m_index_reg <= m_index_next;
        m_code_reg  <= m_code_next;
        m_last_reg  <= m_last_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {(M_TDATA_W - INDEX_W - CODE_W)'(0), m_code_reg, m_index_reg};
    assign m_axis_tlast  = m_last_reg;

    // ---------------- checks
    a_no_bcd_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CONV |-> !carry[BCD_CELLS-1])
        else $error("BCD chain overflowed its top cell");

    a_trimmed_before_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT |-> !need_trim)
        else $error("digit writes started with too many digits left");

    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_last_reg |-> m_index_reg == IDX_LAST)
        else $error("last flag on a digit other than the top one");

    a_run_ends_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT && out_free && idx_reg == IDX_LAST |=> state_reg == ST_IDLE)
        else $error("formatter did not return to idle after the last digit");

endmodule

### bench/ddd_digit_checker.sv
// Scoreboard for the decimal digit display formatter: watches both stream channels,
// predicts the DIGIT_COUNT digit writes of each accepted request and compares them in order.
// Depends on ddd_pkg for widths and code-B constants.
module ddd_digit_checker #(
    parameter int DIGIT_COUNT = ddd_pkg::DIGIT_COUNT_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    input  logic [ddd_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [ddd_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input  logic                          m_axis_tlast,
    output int                            error_count,
    output int                            writes_due
);
    timeunit 1ns;
    timeprecision 1ps;

    import ddd_pkg::*;

    localparam int unsigned FIT_LIMIT = 10 ** DIGIT_COUNT;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [CODE_W-1:0]  code;
        logic               last;
    } digit_write_t;

    digit_write_t expected_writes[$];

    initial begin
        error_count = 0;
        writes_due  = 0;
    end

    // Expected display writes for one value/point pair, least significant digit first
    function automatic void queue_digit_writes(input logic [VALUE_W-1:0] value,
                                               input logic [POINT_W-1:0] point_raw);
        logic [VALUE_W-1:0] rest;
        int                 point;
        int                 point_slot;
        logic [DIGIT_W-1:0] digit;
        digit_write_t       w;
        rest  = value;
        point = int'($signed(point_raw));
        // drop low digits until the value fits the display
        while (rest >= FIT_LIMIT)
            rest = rest / 10;
        if (point < -1)
            point = -1;
        if (point > DIGIT_COUNT)
            point = DIGIT_COUNT;
        point_slot = point + 1;  // one-based, 0 = no point
        for (int i = 1; i <= DIGIT_COUNT; i++) begin
            digit   = DIGIT_W'(rest % 10);
            w.index = INDEX_W'(i);
            w.last  = (i == DIGIT_COUNT);
            if (i < point_slot)
                w.code = CODE_W'(digit);
            else if (i == point_slot)
                w.code = CODE_W'(digit) | CODE_POINT;
            else if (rest != 0)
                w.code = CODE_W'(digit);
            else
                w.code = CODE_BLANK;
            expected_writes.push_back(w);
            rest = rest / 10;
        end
    endfunction

    always @(posedge aclk) begin
        digit_write_t want;
        digit_write_t got;
        if (aresetn) begin
            // results first: a write can never belong to a request taken at this edge
            if (m_axis_tvalid && m_axis_tready) begin
                got.index = m_axis_tdata[INDEX_W-1:0];
                got.code  = m_axis_tdata[INDEX_W +: CODE_W];
                got.last  = m_axis_tlast;
                if (expected_writes.size() == 0) begin
                    $display("%0t: unexpected digit write index=%0d code=%02h last=%0b",
                             $time, got.index, got.code, got.last);
                    error_count++;
                end else begin
                    want = expected_writes.pop_front();
                    if (got !== want) begin
                        $display("%0t: digit write mismatch: expected index=%0d code=%02h",
                                 $time, want.index, want.code,
                                 " last=%0b, got index=%0d code=%02h last=%0b",
                                 want.last, got.index, got.code, got.last);
                        error_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                queue_digit_writes(s_axis_tdata[VALUE_W-1:0],
                                   s_axis_tdata[VALUE_W +: POINT_W]);
        end
        writes_due <= expected_writes.size();
    end

endmodule

### bench/decimal_digit_display_formatter_tb.sv
// Top of the formatter testbench: clock, reset, request stimulus and verdict.
// Depends on ddd_pkg, decimal_digit_display_formatter and ddd_digit_checker.
module decimal_digit_display_formatter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ddd_pkg::*;

    localparam int ITEMS_PER_PHASE = 25;
    localparam int DRAIN_CYCLES    = 60;    // a little over one request's latency

    logic                   aclk          = 1'b0;
    logic                   aresetn       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;   // digit_index, digit_code, zero fill
    logic                   m_axis_tlast;

    int error_count;
    int writes_due;

    // percent chance per cycle of the sender idling / the sink stalling
    int idle_pct  = 0;
    int stall_pct = 0;

    decimal_digit_display_formatter dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // value, point_digit, zero fill
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // digit_index, digit_code, zero fill
        .m_axis_tlast  (m_axis_tlast)
    );

    ddd_digit_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .error_count   (error_count),
        .writes_due    (writes_due)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Sink: random back-pressure at the rate of the current phase
    always @(posedge aclk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Hard stop at 2 ms, well beyond the slowest run of ~120 requests
    // with stalled digit writes.
    initial begin
        #2ms;
        $display("decimal_digit_display_formatter_tb: errors");
        $finish;
    end

    // One request; valid stays up across back-to-back requests so it is
    // never dropped and raised in the same step.
    task automatic send_request(input logic [VALUE_W-1:0] value, input int point);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W - VALUE_W - POINT_W){1'b0}}, POINT_W'(point), value};
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
    endtask

    // Values spread over small numbers, the 8/9/10-digit truncation
    // boundaries, the top of the range and fully random words.
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 999);
            1: return 32'd99_999_000 + $urandom_range(0, 2000);
            2: return 32'd999_999_000 + $urandom_range(0, 2000);
            3: return 32'hFFFF_FFFF - $urandom_range(0, 5000);
            4: return $urandom_range(0, 99_999_999);
            default: return $urandom;
        endcase
    endfunction

    // Mostly legal positions -1..8; now and then any 5-bit pattern to hit clamping
    function automatic int pick_point();
        if ($urandom_range(0, 99) < 80)
            return int'($urandom_range(0, 9)) - 1;
        return int'($signed(POINT_W'($urandom_range(0, 31))));
    endfunction

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed requests, no idling on either side.
        // zero value: all blank with no point, leading zeros at point 8
        send_request(32'd0, -1);
        send_request(32'd0, 0);
        send_request(32'd0, 3);
        send_request(32'd0, 8);
        // largest value: truncated by two digits to 42949672
        send_request(32'hFFFF_FFFF, -1);
        send_request(32'hFFFF_FFFF, 7);
        send_request(32'hFFFF_FFFF, 8);
        // largest 8-digit value, and the first values that need truncation
        send_request(32'd99_999_999, 4);
        send_request(32'd100_000_000, 0);
        send_request(32'd999_999_999, 2);
        send_request(32'd1_000_000_000, 1);
        // point clamping: below -1 means no point, above 8 means leading zeros only
        send_request(32'd1234, -2);
        send_request(32'd1234, -16);
        send_request(32'd1234, 9);
        send_request(32'd1234, 15);
        // point above, at and below the top nonzero digit
        send_request(32'd5, 5);
        send_request(32'd50, 1);
        send_request(32'd7006, 2);
        send_request(32'h5555_5555, 6);
        send_request(32'hAAAA_AAAA, 5);

        // Random requests: no idling, sender idle, sink stalling, both
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 50; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 50; end
                default: begin idle_pct = 21; stall_pct = 21; end
            endcase
            repeat (ITEMS_PER_PHASE)
                send_request(pick_value(), pick_point());
        end
        s_axis_tvalid <= 1'b0;

        // one edge so the checker's count includes the final request
        @(posedge aclk);
        while (writes_due != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0)
            $display("decimal_digit_display_formatter_tb: clean");
        else
            $display("decimal_digit_display_formatter_tb: errors");
        $finish;
    end

endmodule

### decimal_digit_display_formatter.f
hw/rtl/ddd_pkg.sv
hw/rtl/ddd_cell.sv
hw/rtl/decimal_digit_display_formatter.sv
bench/ddd_digit_checker.sv
bench/decimal_digit_display_formatter_tb.sv
